/* src/occupancy_grid_tube_obstacle_marker_defines.svh */
// assertion macros shared by the obstacle marker rtl
`ifndef OCCUPANCY_GRID_TUBE_OBSTACLE_MARKER_DEFINES_SVH
`define OCCUPANCY_GRID_TUBE_OBSTACLE_MARKER_DEFINES_SVH

// same-cycle implication, held off during reset
`define OGT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ogt check failed: same-cycle implication");

// next-cycle implication, held off during reset
`define OGT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ogt check failed: next-cycle implication");

`endif

/* src/ogt_pkg.sv */
// types and constants for the occupancy grid tube obstacle marker
`default_nettype none
package ogt_pkg;

   localparam int COST_W   = 8;
   localparam int THRESH_W = 7;
   localparam int GRID_W   = 13;
   localparam int RADIUS_W = 28;
   localparam int TRIG_W   = 16;
   localparam int MODE_W   = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 28;

   localparam logic signed [COST_W-1:0] COST_UNKNOWN  = -8'sd1;
   localparam logic signed [COST_W-1:0] MARK_UNKNOWN  = -8'sd1;
   localparam logic signed [COST_W-1:0] MARK_FREE     = 8'sd0;
   localparam logic signed [COST_W-1:0] MARK_OBSTACLE = 8'sd100;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd50;
   localparam logic [GRID_W-1:0]   GRID_RESET   = 13'd256;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 28'd262144;
   localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 16'sd16384;
   localparam logic signed [TRIG_W-1:0] TRIG_ZERO = 16'sd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_THRESHOLD   = 3'd0,
      REG_GRID_WIDTH  = 3'd1,
      REG_RADIUS      = 3'd2,
      REG_HEADING_COS = 3'd3,
      REG_HEADING_SIN = 3'd4,
      REG_LOOK_COS    = 3'd5,
      REG_LOOK_SIN    = 3'd6,
      REG_MOTION_MODE = 3'd7
   } csr_index_type;

   localparam logic [MODE_W-1:0] MODE_STRAIGHT_FWD = 3'd0;
   localparam logic [MODE_W-1:0] MODE_STRAIGHT_REV = 3'd1;
   localparam logic [MODE_W-1:0] MODE_LEFT_FWD     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_LEFT_REV     = 3'd3;
   localparam logic [MODE_W-1:0] MODE_RIGHT_FWD    = 3'd4;
   localparam logic [MODE_W-1:0] MODE_RIGHT_REV    = 3'd5;

   typedef struct packed {
      logic [THRESH_W-1:0]        obstacle_threshold;
      logic [GRID_W-1:0]          grid_width;
      logic [RADIUS_W-1:0]        tube_radius_scaled;
      logic signed [TRIG_W-1:0]   heading_cos;
      logic signed [TRIG_W-1:0]   heading_sin;
      logic signed [TRIG_W-1:0]   look_cos;
      logic signed [TRIG_W-1:0]   look_sin;
      logic [MODE_W-1:0]          motion_mode;
   } cfg_type;

   // cost classification carried down the pipe
   typedef struct packed {
      logic unknown;
      logic candidate;
   } cell_class_type;

endpackage
`default_nettype wire

/* src/ogt_front.sv */
// cell position counters, cost classification and centre offset register
`default_nettype none
module ogt_front #(
   parameter int CW   = 12,
   parameter int MAXW = 4096,
   parameter int OW   = 14
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          accept,
   input  wire signed [ogt_pkg::COST_W-1:0] cell_cost,
   input  wire                          first_cell,
   input  ogt_pkg::cfg_type             cfg,
   output logic signed [OW-1:0]         dx_ff,
   output logic signed [OW-1:0]         dy_ff,
   output ogt_pkg::cell_class_type      class_ff
);
   import ogt_pkg::*;
   `include "occupancy_grid_tube_obstacle_marker_defines.svh"

   localparam int XW = (CW + 1 > GRID_W) ? CW + 1 : GRID_W;
   localparam logic [CW:0]   COL_LIMIT = (CW + 1)'(MAXW);
   localparam logic [CW-1:0] ROW_TOP   = CW'(MAXW - 1);

   logic [CW-1:0] col_ff, col_in, row_ff, row_in;
   logic [CW-1:0] col_use, row_use;
   logic [CW:0]   col_next;
   logic          wrap;
   logic signed [OW-1:0] dx_in, dy_in;
   cell_class_type class_in;

   always_comb begin
      col_use  = first_cell ? '0 : col_ff;
      row_use  = first_cell ? '0 : row_ff;
      col_next = {1'b0, col_use} + (CW + 1)'(1);
      wrap     = (XW'(col_next) >= XW'(cfg.grid_width)) || (col_next >= COL_LIMIT);
      col_in   = wrap ? '0 : col_next[CW-1:0];
      row_in   = (wrap && (row_use < ROW_TOP)) ? row_use + CW'(1) : row_use;
      // offsets in half-cells from the grid centre
      dx_in    = $signed(OW'({col_use, 1'b0})) - $signed(OW'(cfg.grid_width));
      dy_in    = $signed(OW'({row_use, 1'b0})) - $signed(OW'(cfg.grid_width));
      class_in.unknown   = (cell_cost == COST_UNKNOWN);
      class_in.candidate = (cell_cost >= $signed({1'b0, cfg.obstacle_threshold}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         class_ff <= class_in;
      end
   end

   // row only moves forward within a scan
   `OGT_ASSERT_NEXT(a_row_monotonic, clock, reset, accept && !first_cell, row_ff >= $past(row_ff))
   `OGT_ASSERT_NOW(a_row_saturates, clock, reset, 1'b1, row_ff <= ROW_TOP)

endmodule
`default_nettype wire

/* src/ogt_rotate.sv */
// products of the cell offset with heading and look trig values
`default_nettype none
module ogt_rotate #(
   parameter int OW = 14,
   parameter int PW = 30
) (
   input  ogt_pkg::cfg_type         cfg,
   input  wire signed [OW-1:0]      dx,
   input  wire signed [OW-1:0]      dy,
   output logic signed [PW-1:0]     hc_dx,
   output logic signed [PW-1:0]     hs_dy,
   output logic signed [PW-1:0]     hc_dy,
   output logic signed [PW-1:0]     hs_dx,
   output logic signed [PW-1:0]     lc_dy,
   output logic signed [PW-1:0]     ls_dx
);
   import ogt_pkg::*;

   always_comb begin
      hc_dx = PW'($signed(cfg.heading_cos)) * PW'(dx);
      hs_dy = PW'($signed(cfg.heading_sin)) * PW'(dy);
      hc_dy = PW'($signed(cfg.heading_cos)) * PW'(dy);
      hs_dx = PW'($signed(cfg.heading_sin)) * PW'(dx);
      lc_dy = PW'($signed(cfg.look_cos)) * PW'(dy);
      ls_dx = PW'($signed(cfg.look_sin)) * PW'(dx);
   end

endmodule
`default_nettype wire

/* src/ogt_tube.sv */
// robot-frame sums, tube tests per motion mode and the mark register
`default_nettype none
module ogt_tube #(
   parameter int PW   = 30,
   parameter int CMPW = 31
) (
   input  wire                      clock,
   input  wire                      load,
   input  ogt_pkg::cfg_type         cfg,
   input  wire signed [PW-1:0]      hc_dx,
   input  wire signed [PW-1:0]      hs_dy,
   input  wire signed [PW-1:0]      hc_dy,
   input  wire signed [PW-1:0]      hs_dx,
   input  wire signed [PW-1:0]      lc_dy,
   input  wire signed [PW-1:0]      ls_dx,
   input  ogt_pkg::cell_class_type  class_in,
   output logic signed [ogt_pkg::COST_W-1:0] mark_ff
);
   import ogt_pkg::*;

   logic signed [CMPW-1:0] rel_x, rel_y, look_y, r_pos, r_neg;
   logic fwd, rev, hit;
   logic signed [COST_W-1:0] mark_in;

   always_comb begin
      rel_x  = CMPW'(hc_dx) + CMPW'(hs_dy);
      rel_y  = CMPW'(hc_dy) - CMPW'(hs_dx);
      look_y = CMPW'(lc_dy) - CMPW'(ls_dx);
      r_pos  = $signed(CMPW'(cfg.tube_radius_scaled));
      r_neg  = -r_pos;
      fwd    = rel_x > 0;
      rev    = rel_x < 0;
      case (cfg.motion_mode)
         MODE_STRAIGHT_FWD: hit = (rel_y < r_pos) && (rel_y > r_neg) && fwd;
         MODE_STRAIGHT_REV: hit = (rel_y < r_pos) && (rel_y > r_neg) && rev;
         MODE_LEFT_FWD:     hit = (rel_y > r_neg) && (look_y < r_pos) && fwd;
         MODE_LEFT_REV:     hit = (rel_y < r_pos) && (look_y < r_pos) && rev;
         MODE_RIGHT_FWD:    hit = (rel_y < r_pos) && (look_y > r_neg) && fwd;
         MODE_RIGHT_REV:    hit = (rel_y > r_neg) && (look_y > r_neg) && rev;
         default:           hit = 1'b0;
      endcase
      if (class_in.unknown) begin
         mark_in = MARK_UNKNOWN;
      end else if (class_in.candidate && hit) begin
         mark_in = MARK_OBSTACLE;
      end else begin
         mark_in = MARK_FREE;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mark_ff <= mark_in;
      end
   end

endmodule
`default_nettype wire

/* src/occupancy_grid_tube_obstacle_marker.sv */
// top level of the occupancy grid tube obstacle marker
// Streams occupancy-grid cells in raster order and returns one mark beat per cell beat:
// -1 for an unknown cell, 100 for a cell at or above the threshold that lies inside
// the motion tube, 0 otherwise. Column and row counters track the cell position; a
// beat with first_cell set restarts them. The row counter saturates at the last row.
// Throughput is one cell per clock unless the receiver holds off. The edge that takes a cell beat
// loads the cell register with its cost class and its half-cell offsets from the grid centre; the
// mark register is then loaded from it through the six trig products, the robot-frame sums and
// the tube compares once it is empty or being drained, and the mark beat is offered from there.
// Two beats can be in flight; req_ready follows rsp_ready in the same cycle and only
// falls while both registers are full and the receiver holds off. csr_ready is always
// high; registers should only be written while no cell is in flight.
`default_nettype none
module occupancy_grid_tube_obstacle_marker #(
   parameter int MAX_GRID_WIDTH = 4096
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire signed [ogt_pkg::COST_W-1:0]     req_cell_cost,
   input  wire                                  req_first_cell,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic signed [ogt_pkg::COST_W-1:0]    rsp_cell_mark,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [ogt_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire [ogt_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import ogt_pkg::*;
   `include "occupancy_grid_tube_obstacle_marker_defines.svh"

   // counter width, offset width, product width and compare width
   localparam int CW   = $clog2(MAX_GRID_WIDTH);
   localparam int OW   = (CW + 2 > GRID_W + 1) ? CW + 2 : GRID_W + 1;
   localparam int PW   = OW + TRIG_W;
   localparam int CMPW = (PW + 1 > RADIUS_W + 1) ? PW + 1 : RADIUS_W + 1;

   cfg_type cfg_ff, cfg_in;

   // occupancy of the cell register and the mark register
   logic v1_ff, v1_in, v2_ff, v2_in;
   logic en1, en2, accept;
   logic mark_legal;

   logic signed [OW-1:0] dx, dy;
   cell_class_type class1;
   logic signed [PW-1:0] hc_dx, hs_dy, hc_dy, hs_dx, lc_dy, ls_dx;

   // configuration writes, taken every cycle
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            REG_THRESHOLD:   cfg_in.obstacle_threshold = csr_wdata[THRESH_W-1:0];
            REG_GRID_WIDTH:  cfg_in.grid_width         = csr_wdata[GRID_W-1:0];
            REG_RADIUS:      cfg_in.tube_radius_scaled = csr_wdata[RADIUS_W-1:0];
            REG_HEADING_COS: cfg_in.heading_cos        = $signed(csr_wdata[TRIG_W-1:0]);
            REG_HEADING_SIN: cfg_in.heading_sin        = $signed(csr_wdata[TRIG_W-1:0]);
            REG_LOOK_COS:    cfg_in.look_cos           = $signed(csr_wdata[TRIG_W-1:0]);
            REG_LOOK_SIN:    cfg_in.look_sin           = $signed(csr_wdata[TRIG_W-1:0]);
            REG_MOTION_MODE: cfg_in.motion_mode        = csr_wdata[MODE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_threshold <= THRESH_RESET;
         cfg_ff.grid_width         <= GRID_RESET;
         cfg_ff.tube_radius_scaled <= RADIUS_RESET;
         cfg_ff.heading_cos        <= TRIG_ONE;
         cfg_ff.heading_sin        <= TRIG_ZERO;
         cfg_ff.look_cos           <= TRIG_ONE;
         cfg_ff.look_sin           <= TRIG_ZERO;
         cfg_ff.motion_mode        <= MODE_STRAIGHT_FWD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // a stage moves on when its successor is empty or moving too
   always_comb begin
      en2       = !v2_ff || rsp_ready;
      en1       = !v1_ff || en2;
      req_ready = en1;
      accept    = req_valid && en1;
      v1_in     = en1 ? req_valid : v1_ff;
      v2_in     = en2 ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   assign rsp_valid = v2_ff;

   ogt_front #(
      .CW   (CW),
      .MAXW (MAX_GRID_WIDTH),
      .OW   (OW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cell_cost  (req_cell_cost),
      .first_cell (req_first_cell),
      .cfg        (cfg_ff),
      .dx_ff      (dx),
      .dy_ff      (dy),
      .class_ff   (class1)
   );

   ogt_rotate #(
      .OW (OW),
      .PW (PW)
   ) u_rotate (
      .cfg   (cfg_ff),
      .dx    (dx),
      .dy    (dy),
      .hc_dx (hc_dx),
      .hs_dy (hs_dy),
      .hc_dy (hc_dy),
      .hs_dx (hs_dx),
      .lc_dy (lc_dy),
      .ls_dx (ls_dx)
   );

   ogt_tube #(
      .PW   (PW),
      .CMPW (CMPW)
   ) u_tube (
      .clock    (clock),
      .load     (en2),
      .cfg      (cfg_ff),
      .hc_dx    (hc_dx),
      .hs_dy    (hs_dy),
      .hc_dy    (hc_dy),
      .hs_dx    (hs_dx),
      .lc_dy    (lc_dy),
      .ls_dx    (ls_dx),
      .class_in (class1),
      .mark_ff  (rsp_cell_mark)
   );

   assign mark_legal = (rsp_cell_mark == MARK_UNKNOWN) || (rsp_cell_mark == MARK_FREE) ||
                       (rsp_cell_mark == MARK_OBSTACLE);

   // marks are only ever one of the three codes
   `OGT_ASSERT_NOW(a_mark_code, clock, reset, rsp_valid, mark_legal)
   // an empty first stage always takes a beat
   `OGT_ASSERT_NOW(a_ready_when_room, clock, reset, !v1_ff, req_ready)
   // an accepted beat occupies the first stage
   `OGT_ASSERT_NEXT(a_accept_fills, clock, reset, accept, v1_ff)

endmodule
`default_nettype wire

/* tb/tb.sv */
// self-checking bench for the occupancy grid tube obstacle marker
`timescale 1ns / 100ps
`default_nettype none
module tb;
   import ogt_pkg::*;

   localparam int GRID_LIMIT    = 4096;   // column wrap and row saturation point
   localparam int LONG_HOLD     = 60;     // receiver back-pressure stretch, in cycles
   localparam int SETTLE_CYCLES = 12;     // pipe is two deep, leave some slack
   localparam int RANDOM_CELLS  = 400;

   // eight headings at 45 degree steps, Q1.14
   localparam logic signed [TRIG_W-1:0] ROT_COS [8] =
      '{16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384, -16'sd11585, 16'sd0,
        16'sd11585};
   localparam logic signed [TRIG_W-1:0] ROT_SIN [8] =
      '{16'sd0, 16'sd11585, 16'sd16384, 16'sd11585, 16'sd0, -16'sd11585, -16'sd16384,
        -16'sd11585};

   // opening 4x4 scan plus a restart; only the cell at column 3, row 2 is in the tube
   localparam logic signed [COST_W-1:0] PROBE_COSTS [20] =
      '{8'sd127, -8'sd1, -8'sd128, 8'sd0, 8'sd49, 8'sd50, 8'sd51, 8'sd100, -8'sd2, 8'sd126,
        -8'sd1, 8'sd127, 8'sd50, 8'sd49, 8'sd80, -8'sd128, 8'sd127, -8'sd1, 8'sd60, 8'sd0};

   typedef struct packed {
      logic signed [COST_W-1:0] cost;
      logic                     first;
   } cell_beat_type;

   // clock, reset and every block input start at a known value
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic signed [COST_W-1:0] req_cell_cost = '0;
   logic req_first_cell = 1'b0;
   logic rsp_ready = 1'b0;
   logic csr_valid = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   wire req_ready;
   wire rsp_valid;
   wire signed [COST_W-1:0] rsp_cell_mark;
   wire csr_ready;

   occupancy_grid_tube_obstacle_marker #(
      .MAX_GRID_WIDTH(GRID_LIMIT)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_cost (req_cell_cost),
      .req_first_cell(req_first_cell),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_mark (rsp_cell_mark),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow copy of the register file, updated as each write beat lands
   logic [THRESH_W-1:0]      threshold   = THRESH_RESET;
   logic [GRID_W-1:0]        grid_width  = GRID_RESET;
   logic [RADIUS_W-1:0]      radius      = RADIUS_RESET;
   logic signed [TRIG_W-1:0] hd_cos      = TRIG_ONE;
   logic signed [TRIG_W-1:0] hd_sin      = TRIG_ZERO;
   logic signed [TRIG_W-1:0] lk_cos      = TRIG_ONE;
   logic signed [TRIG_W-1:0] lk_sin      = TRIG_ZERO;
   logic [MODE_W-1:0]        motion_mode = MODE_STRAIGHT_FWD;

   // raster position of the next cell, as the block should hold it
   logic [11:0] col_pos = '0;
   logic [11:0] row_pos = '0;

   cell_beat_type            cell_queue[$];      // cells waiting to be offered
   logic signed [COST_W-1:0] expected_marks[$];  // marks owed by the block, oldest first
   cell_beat_type            next_cell;

   int cells_queued = 0;
   int cells_taken  = 0;
   int mismatches   = 0;

   // pacing knobs, set by the stimulus between phases
   int gap_max     = 0;
   int stall_pct   = 0;
   int hold_asked  = 0;
   int hold_served = 0;
   int burst_left  = 0;
   int gap_left    = 0;
   int stall_left  = 0;
   int hold_left   = 0;

   // mark for one cell at the current raster position, then advance the counters
   function automatic logic signed [COST_W-1:0] mark_cell(
      input logic signed [COST_W-1:0] cost, input logic first);
      longint dx, dy, rel_x, rel_y, look_y, r;
      logic hit;
      logic signed [COST_W-1:0] mark;
      logic [12:0] next_col;
      if (first) begin
         col_pos = '0;
         row_pos = '0;
      end
      // offset from the centre in half-cells; rows are centred on the width as well
      dx = 2 * longint'(col_pos) - longint'(grid_width);
      dy = 2 * longint'(row_pos) - longint'(grid_width);
      // inverse rotation into the robot frame, no rounding anywhere
      rel_x  = longint'(hd_cos) * dx + longint'(hd_sin) * dy;
      rel_y  = longint'(hd_cos) * dy - longint'(hd_sin) * dx;
      look_y = longint'(lk_cos) * dy - longint'(lk_sin) * dx;
      r      = longint'(radius);
      case (motion_mode)
         MODE_STRAIGHT_FWD: hit = (rel_y < r) && (rel_y > -r) && (rel_x > 0);
         MODE_STRAIGHT_REV: hit = (rel_y < r) && (rel_y > -r) && (rel_x < 0);
         MODE_LEFT_FWD:     hit = (rel_y > -r) && (look_y < r) && (rel_x > 0);
         MODE_LEFT_REV:     hit = (rel_y < r) && (look_y < r) && (rel_x < 0);
         MODE_RIGHT_FWD:    hit = (rel_y < r) && (look_y > -r) && (rel_x > 0);
         MODE_RIGHT_REV:    hit = (rel_y > -r) && (look_y > -r) && (rel_x < 0);
         default:           hit = 1'b0;   // unused modes never mark
      endcase
      if (cost == COST_UNKNOWN)
         mark = MARK_UNKNOWN;
      else if (int'(cost) < int'(threshold))
         mark = MARK_FREE;                // other negative costs land here too
      else
         mark = hit ? MARK_OBSTACLE : MARK_FREE;
      // wrap at the grid width or at the hard limit, whichever comes first
      next_col = {1'b0, col_pos} + 13'd1;
      if (next_col >= grid_width || next_col >= GRID_LIMIT) begin
         col_pos = '0;
         if (row_pos < GRID_LIMIT - 1)
            row_pos = row_pos + 12'd1;
      end else begin
         col_pos = next_col[11:0];
      end
      return mark;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // driver: bursts of beats with random gaps, payload held until taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_marks.insert(expected_marks.size(),
                                  mark_cell(req_cell_cost, req_first_cell));
            cells_taken++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cell_queue.size() > 0) begin
               next_cell = cell_queue.pop_front();
               req_valid      <= 1'b1;
               req_cell_cost  <= next_cell.cost;
               req_first_cell <= next_cell.first;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 12);
                  gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each mark beat, and throttles the result side
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_marks.size() == 0)
               report_mismatch($sformatf("mark %0d with no cell pending", rsp_cell_mark));
            else if (rsp_cell_mark !== expected_marks[0])
               report_mismatch($sformatf("cell_mark got %0d want %0d", rsp_cell_mark,
                                         expected_marks.pop_front()));
            else
               void'(expected_marks.pop_front());
         end
         // a long hold-off lets the pipe fill and push back on the sender
         if (hold_asked != hold_served) begin
            hold_left   = LONG_HOLD;
            hold_served = hold_asked;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < stall_pct)
               stall_left = $urandom_range(1, 5);
         end
      end
   end

   // one register write; bits above the field are sometimes filled with junk
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value,
                            input int bits);
      logic [CSR_DATA_W-1:0] keep, data;
      logic [31:0] junk;
      keep = '1;
      keep = keep >> (CSR_DATA_W - bits);
      junk = $urandom();
      data = value & keep;
      if ($urandom_range(0, 1) == 1)
         data = data | (junk[CSR_DATA_W-1:0] & ~keep);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_THRESHOLD:   threshold   = data[THRESH_W-1:0];
         REG_GRID_WIDTH:  grid_width  = data[GRID_W-1:0];
         REG_RADIUS:      radius      = data[RADIUS_W-1:0];
         REG_HEADING_COS: hd_cos      = data[TRIG_W-1:0];
         REG_HEADING_SIN: hd_sin      = data[TRIG_W-1:0];
         REG_LOOK_COS:    lk_cos      = data[TRIG_W-1:0];
         REG_LOOK_SIN:    lk_sin      = data[TRIG_W-1:0];
         REG_MOTION_MODE: motion_mode = data[MODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic program_block(input int thr, input int width, input int rad,
                                input logic signed [TRIG_W-1:0] hc,
                                input logic signed [TRIG_W-1:0] hs,
                                input logic signed [TRIG_W-1:0] lc,
                                input logic signed [TRIG_W-1:0] ls, input int mode);
      write_reg(REG_THRESHOLD, CSR_DATA_W'(thr), THRESH_W);
      write_reg(REG_GRID_WIDTH, CSR_DATA_W'(width), GRID_W);
      write_reg(REG_RADIUS, CSR_DATA_W'(rad), RADIUS_W);
      write_reg(REG_HEADING_COS, CSR_DATA_W'(hc), TRIG_W);
      write_reg(REG_HEADING_SIN, CSR_DATA_W'(hs), TRIG_W);
      write_reg(REG_LOOK_COS, CSR_DATA_W'(lc), TRIG_W);
      write_reg(REG_LOOK_SIN, CSR_DATA_W'(ls), TRIG_W);
      write_reg(REG_MOTION_MODE, CSR_DATA_W'(mode), MODE_W);
      @(negedge clock);
   endtask

   // mostly a 45 degree step, sometimes raw bits whose magnitude can pass one
   task automatic pick_rotation(output logic signed [TRIG_W-1:0] c,
                                output logic signed [TRIG_W-1:0] s);
      int a;
      a = $urandom_range(0, 7);
      if ($urandom_range(0, 9) < 7) begin
         c = ROT_COS[a];
         s = ROT_SIN[a];
      end else begin
         c = TRIG_W'($urandom());
         s = TRIG_W'($urandom());
      end
   endtask

   // unknowns, anything at all, or a candidate at or above the threshold
   function automatic logic signed [COST_W-1:0] pick_cost();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2)
         return COST_UNKNOWN;
      else if (sel < 4)
         return COST_W'($urandom());
      else
         return COST_W'($urandom_range(int'(threshold), 127));
   endfunction

   task automatic queue_cell(input logic signed [COST_W-1:0] cost, input logic first);
      cell_beat_type beat;
      beat.cost  = cost;
      beat.first = first;
      cell_queue.insert(cell_queue.size(), beat);
      cells_queued++;
   endtask

   task automatic set_pace(input int gaps, input int stalls);
      gap_max   = gaps;
      stall_pct = stalls;
   endtask

   // sender stays quiet until every mark owed has come back
   task automatic wait_drained();
      while (cells_taken != cells_queued || expected_marks.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int phase, width, rad, n, scan_len, thr, mode, random_cells;
      logic signed [TRIG_W-1:0] hc, hs, lc, ls;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: 4x4 grid, one-cell tube straight ahead, cost extremes and threshold edges
      program_block(50, 4, 2 * 16384, TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO,
                    int'(MODE_STRAIGHT_FWD));
      set_pace(0, 0);
      for (int i = 0; i < 20; i++)
         queue_cell(PROBE_COSTS[i], (i == 0 || i == 16));
      wait_drained();

      // zero width: every cell wraps and the centre sits at the origin
      pick_rotation(hc, hs);
      pick_rotation(lc, ls);
      program_block(0, 0, $urandom_range(0, 1 << 20), hc, hs, lc, ls, int'(MODE_LEFT_REV));
      set_pace(2, 20);
      for (int i = 0; i < 8; i++)
         queue_cell(pick_cost(), (i == 0));
      wait_drained();

      // one-wide grid: every cell starts a new row
      pick_rotation(hc, hs);
      pick_rotation(lc, ls);
      program_block(10, 1, $urandom_range(0, 1 << 27), hc, hs, lc, ls, $urandom_range(0, 5));
      set_pace(1, 10);
      for (int i = 0; i < 40; i++)
         queue_cell(pick_cost(), (i == 0));
      wait_drained();

      // widest width field: one long row well off the centre
      pick_rotation(hc, hs);
      pick_rotation(lc, ls);
      program_block(127, 8191, int'(28'hFFFFFFF), hc, hs, lc, ls, int'(MODE_STRAIGHT_REV));
      set_pace(1, 10);
      for (int i = 0; i < 40; i++)
         queue_cell(pick_cost(), (i == 0));
      wait_drained();

      // random phases: well-formed scans of grids, mostly small, with stray restarts mixed in
      phase        = 0;
      random_cells = 0;
      while (random_cells < RANDOM_CELLS) begin
         case ($urandom_range(0, 19))
            0:       width = 0;
            1:       width = GRID_LIMIT;
            2:       width = 8191;
            3:       width = $urandom_range(13, 8191);
            default: width = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 9))
            0:       thr = 0;
            1:       thr = 127;
            default: thr = $urandom_range(0, 127);
         endcase
         case ($urandom_range(0, 9))
            0:       rad = 0;
            1:       rad = int'(28'hFFFFFFF);
            default: rad = $urandom_range(0, ((width > 64 ? 64 : width) + 2) * 32768);
         endcase
         mode = (phase < 16) ? phase % 8 : $urandom_range(0, 7);
         pick_rotation(hc, hs);
         pick_rotation(lc, ls);
         program_block(thr, width, rad, hc, hs, lc, ls, mode);
         // some phases run flat out, others with heavy idling on either side
         case (phase % 4)
            0:       set_pace(0, 0);
            1:       set_pace(3, 25);
            2:       set_pace(8, 60);
            default: set_pace($urandom_range(0, 8), $urandom_range(0, 70));
         endcase
         if (phase == 4)
            set_pace(0, 0);
         n        = $urandom_range(20, 50);
         scan_len = (width >= 1 && width <= 12) ? width * width : 0;
         for (int k = 0; k < n; k++)
            queue_cell(pick_cost(), (k == 0) || (scan_len > 0 && k % scan_len == 0) ||
                                    ($urandom_range(0, 24) == 0));
         if (phase == 4)
            hold_asked++;
         random_cells += n;
         phase++;
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("[occupancy_grid_tube_obstacle_marker] OK");
      else
         $display("[occupancy_grid_tube_obstacle_marker] ERROR");
      $finish;
   end

   // watchdog well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("[occupancy_grid_tube_obstacle_marker] ERROR");
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/ogt_pkg.sv
src/ogt_front.sv
src/ogt_rotate.sv
src/ogt_tube.sv
src/occupancy_grid_tube_obstacle_marker.sv
tb/tb.sv
